/* design/dsq_pkg.sv */
// ----------------------------------------------------------------------------
// dsq_pkg: shared types and constants
// Constants, command/status structs and helpers for the terrain generator.
// ----------------------------------------------------------------------------
package dsq_pkg;

   localparam int GRID_LOG2_DEFAULT = 5;
   localparam int COORD_W = 11;                  // holds 2^10 (highest parameter value)
   localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

   typedef enum logic [1:0] {
      CSR_MIN_HEIGHT = 2'd0,
      CSR_MAX_HEIGHT = 2'd1,
      CSR_ROUGHNESS  = 2'd2,
      CSR_SEED       = 2'd3
   } csr_index_type;

   // datapath operations issued per grid point
   typedef enum logic [1:0] {
      OP_CORNER = 2'd0,
      OP_SQUARE = 2'd1,
      OP_DIAMOND = 2'd2
   } point_op_type;

   typedef struct packed {
      logic                start;   // load lfsr, prepare range
      logic                go;      // compute one point
      point_op_type        op;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  half;
      logic [3:0]          level;
      logic                rd;      // read one point
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic rd_done;
   } dp_status_type;

   function automatic logic [31:0] lfsr_step(input logic [31:0] s);
      logic [31:0] n;
      n = s >> 1;
      if (s[0]) n = n ^ LFSR_TAPS;
      return n;
   endfunction

endpackage

/* design/dsq_datapath.sv */
// ----------------------------------------------------------------------------
// dsq_datapath: grid memory, noise generator and point arithmetic
// Fetches four neighbours one per cycle, averages, adds noise, writes back.
// ----------------------------------------------------------------------------
module dsq_datapath #(
   parameter int GRID_LOG2 = dsq_pkg::GRID_LOG2_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dsq_pkg::dp_cmd_type   cmd,
   output dsq_pkg::dp_status_type status,
   input  logic signed [15:0]    min_height,
   input  logic signed [15:0]    max_height,
   input  logic [14:0]           roughness,
   input  logic [31:0]           seed,
   output logic signed [15:0]    rd_height
);
   import dsq_pkg::*;

   localparam int EDGE  = 1 << GRID_LOG2;
   localparam int SIDE  = EDGE + 1;
   localparam int DEPTH = SIDE * SIDE;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = GRID_LOG2 + 1;

   typedef enum logic [8:0] {
      P_IDLE  = 9'b000000001,
      P_FETCH = 9'b000000010,
      P_WAIT  = 9'b000000100,
      P_ACC   = 9'b000001000,
      P_MUL   = 9'b000010000,
      P_ADD   = 9'b000100000,
      P_WR0   = 9'b001000000,
      P_WR1   = 9'b010000000,
      P_WR2   = 9'b100000000
   } pstate_type;

   logic signed [15:0] mem [DEPTH];
   logic [AW-1:0]      waddr;
   logic               we;
   logic signed [15:0] wdata;
   logic [AW-1:0]      raddr;
   logic signed [15:0] rdata_ff;

   pstate_type         st_ff, st_in;
   logic [31:0]        lfsr_ff, lfsr_in;
   logic signed [15:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [2:0]         k_ff, k_in;          // fetch index
   logic [2:0]         r_ff, r_in;          // reads returned
   logic signed [17:0] sum_ff, sum_in;
   logic [CW-1:0]      x_ff, x_in, y_ff, y_in, h_ff, h_in;
   point_op_type       op_ff, op_in;
   logic [3:0]         lv_ff, lv_in;
   logic [63:0]        prod_ff, prod_in;
   logic signed [17:0] lo_n_ff, lo_n_in;
   logic signed [15:0] val_ff, val_in;
   logic               rdp_ff, rdp_in;
   logic               rdv_ff;

   logic [CW-1:0]      msk;
   logic [CW-1:0]      fx, fy;
   logic [16:0]        span;
   logic [14:0]        amp;
   logic signed [17:0] m18;
   logic signed [18:0] tot;

   function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] xx, input logic [CW-1:0] yy);
      logic [2*CW+1:0] a;
      a = (2*CW+2)'(yy) * (2*CW+2)'(SIDE) + (2*CW+2)'(xx);
      return a[AW-1:0];
   endfunction

   assign msk = CW'(EDGE - 1);
   assign amp = roughness >> lv_ff;

   // neighbour coordinate for fetch k
   always_comb begin
      fx = x_ff;
      fy = y_ff;
      if (op_ff == OP_SQUARE) begin
         unique case (k_ff[1:0])
            2'd0: begin fx = x_ff - h_ff; fy = y_ff - h_ff; end
            2'd1: begin fx = x_ff + h_ff; fy = y_ff - h_ff; end
            2'd2: begin fx = x_ff - h_ff; fy = y_ff + h_ff; end
            default: begin fx = x_ff + h_ff; fy = y_ff + h_ff; end
         endcase
      end else begin
         unique case (k_ff[1:0])
            2'd0: fx = (x_ff - h_ff) & msk;
            2'd1: fx = (x_ff + h_ff) & msk;
            2'd2: fy = (y_ff + h_ff) & msk;
            default: fy = (y_ff - h_ff) & msk;
         endcase
      end
   end

   always_comb begin
      raddr = addr_of(fx, fy);
      if (cmd.rd) raddr = addr_of(cmd.x[CW-1:0], cmd.y[CW-1:0]);
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign m18 = 18'(sum_ff >>> 2);
   assign tot = 19'(m18) + 19'(lo_n_ff) + 19'($signed({1'b0, prod_ff[63:32]}));

   always_comb begin
      st_in = st_ff; lfsr_in = lfsr_ff; lo_in = lo_ff; hi_in = hi_ff;
      k_in = k_ff; r_in = r_ff; sum_in = sum_ff; x_in = x_ff; y_in = y_ff;
      h_in = h_ff; op_in = op_ff; lv_in = lv_ff; prod_in = prod_ff;
      lo_n_in = lo_n_ff; val_in = val_ff; rdp_in = cmd.rd;
      we = 1'b0; waddr = addr_of(x_ff, y_ff); wdata = val_ff;
      span = 17'(hi_ff - lo_ff) + 17'd1;
      if (op_ff != OP_CORNER) span = {1'b0, amp, 1'b0} + 17'd1;
      if (cmd.start) begin
         lfsr_in = (seed == 32'd0) ? 32'd1 : seed;
         if (max_height < min_height) begin
            lo_in = max_height; hi_in = min_height;
         end else begin
            lo_in = min_height; hi_in = max_height;
         end
      end
      unique case (st_ff)
         P_IDLE: if (cmd.go) begin
            x_in = cmd.x[CW-1:0]; y_in = cmd.y[CW-1:0]; h_in = cmd.half[CW-1:0];
            op_in = cmd.op; lv_in = cmd.level; k_in = '0; r_in = '0;
            sum_in = '0;
            st_in = (cmd.op == OP_CORNER) ? P_MUL : P_FETCH;
         end
         P_FETCH: begin
            k_in = k_ff + 3'd1;
            if (k_ff != 3'd0) begin
               sum_in = sum_ff + 18'(rdata_ff); r_in = r_ff + 3'd1;
            end
            if (k_ff == 3'd3) st_in = P_WAIT;
         end
         P_WAIT: begin
            sum_in = sum_ff + 18'(rdata_ff); st_in = P_MUL;
         end
         P_ACC: st_in = P_MUL;
         P_MUL: begin
            lfsr_in = lfsr_step(lfsr_ff);
            prod_in = 64'(lfsr_step(lfsr_ff)) * 64'(span);
            if (op_ff == OP_CORNER) begin
               lo_n_in = 18'(lo_ff); sum_in = '0;
            end else begin
               lo_n_in = -18'($signed({1'b0, amp}));
            end
            st_in = P_ADD;
         end
         P_ADD: begin
            if (tot > 19'sd32767) val_in = 16'sh7FFF;
            else if (tot < -19'sd32768) val_in = -16'sh8000;
            else val_in = 16'(tot);
            st_in = P_WR0;
         end
         P_WR0: begin
            we = 1'b1;
            st_in = (op_ff == OP_DIAMOND) ? P_WR1 : P_IDLE;
         end
         P_WR1: begin
            waddr = addr_of(CW'(EDGE), y_ff);
            we = (x_ff == '0);
            st_in = P_WR2;
         end
         P_WR2: begin
            waddr = addr_of(x_ff, CW'(EDGE));
            we = (y_ff == '0);
            st_in = P_IDLE;
         end
         default: st_in = P_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= P_IDLE; lfsr_ff <= 32'd1; rdp_ff <= 1'b0; rdv_ff <= 1'b0;
         lo_ff <= '0; hi_ff <= '0;
      end else begin
         st_ff <= st_in; lfsr_ff <= lfsr_in; rdp_ff <= rdp_in; rdv_ff <= rdp_ff;
         lo_ff <= lo_in; hi_ff <= hi_in;
      end
      k_ff <= k_in; r_ff <= r_in; sum_ff <= sum_in; x_ff <= x_in; y_ff <= y_in;
      h_ff <= h_in; op_ff <= op_in; lv_ff <= lv_in; prod_ff <= prod_in;
      lo_n_ff <= lo_n_in; val_ff <= val_in;
   end

   assign status.busy = (st_ff != P_IDLE);
   assign status.rd_done = rdp_ff;
   assign rd_height = rdata_ff;

   logic unused_ok;
   assign unused_ok = ^{r_ff, rdv_ff, cmd.x[COORD_W-1:CW], cmd.y[COORD_W-1:CW],
                        cmd.half[COORD_W-1:CW]};
endmodule

/* design/dsq_controller.sv */
// ----------------------------------------------------------------------------
// dsq_controller: sequencer for generate and read requests
// Walks corners, then square and diamond passes per level, one point at a time.
// ----------------------------------------------------------------------------
module dsq_controller #(
   parameter int GRID_LOG2 = dsq_pkg::GRID_LOG2_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_func,
   input  logic [5:0]             req_col,
   input  logic [5:0]             req_row,
   output logic                   req_ready,
   input  dsq_pkg::dp_status_type status,
   output dsq_pkg::dp_cmd_type    cmd,
   output logic                   done,
   output logic                   done_read,
   input  logic                   out_free
);
   import dsq_pkg::*;

   localparam int EDGE = 1 << GRID_LOG2;
   localparam int CW   = GRID_LOG2 + 1;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_CORNER = 6'b000010,
      S_SQ     = 6'b000100,
      S_DIA    = 6'b001000,
      S_READ   = 6'b010000,
      S_WAIT   = 6'b100000
   } state_type;

   state_type     st_ff, st_in;
   logic [CW-1:0] x_ff, x_in, y_ff, y_in, chunk_ff, chunk_in;
   logic [3:0]    lv_ff, lv_in;
   logic [1:0]    cn_ff, cn_in;
   logic          issued_ff, issued_in;
   logic [CW-1:0] half;
   logic [CW-1:0] ccol, crow;

   assign half = chunk_ff >> 1;
   assign ccol = ({5'd0, req_col} > COORD_W'(EDGE)) ? CW'(EDGE) : CW'(req_col);
   assign crow = ({5'd0, req_row} > COORD_W'(EDGE)) ? CW'(EDGE) : CW'(req_row);
   assign req_ready = (st_ff == S_IDLE) && out_free;

   always_comb begin
      st_in = st_ff; x_in = x_ff; y_in = y_ff; chunk_in = chunk_ff; lv_in = lv_ff;
      cn_in = cn_ff; issued_in = issued_ff;
      cmd = '0; done = 1'b0; done_read = 1'b0;
      unique case (st_ff)
         S_IDLE: if (req_valid && req_ready) begin
            if (req_func) begin
               cmd.rd = 1'b1; cmd.x = COORD_W'(ccol); cmd.y = COORD_W'(crow);
               st_in = S_READ;
            end else begin
               cmd.start = 1'b1; cn_in = '0; issued_in = 1'b0;
               chunk_in = CW'(EDGE); lv_in = '0; st_in = S_CORNER;
            end
         end
         S_READ: if (status.rd_done) begin
            done = 1'b1; done_read = 1'b1; st_in = S_IDLE;
         end
         S_CORNER, S_SQ, S_DIA: begin
            if (!issued_ff) begin
               cmd.go = 1'b1; cmd.level = lv_ff; cmd.half = COORD_W'(half);
               if (st_ff == S_CORNER) begin
                  cmd.op = OP_CORNER;
                  cmd.x = cn_ff[0] ? COORD_W'(EDGE) : '0;
                  cmd.y = cn_ff[1] ? COORD_W'(EDGE) : '0;
               end else if (st_ff == S_SQ) begin
                  cmd.op = OP_SQUARE;
                  cmd.x = COORD_W'(x_ff + half); cmd.y = COORD_W'(y_ff + half);
               end else begin
                  cmd.op = OP_DIAMOND; cmd.x = COORD_W'(x_ff); cmd.y = COORD_W'(y_ff);
               end
               issued_in = 1'b1;
            end else if (!status.busy) begin
               issued_in = 1'b0;
               if (st_ff == S_CORNER) begin
                  cn_in = cn_ff + 2'd1;
                  if (cn_ff == 2'd3) begin
                     st_in = S_SQ; x_in = '0; y_in = '0;
                  end
               end else if (st_ff == S_SQ) begin
                  if (CW'(y_ff + chunk_ff) < CW'(EDGE)) y_in = y_ff + chunk_ff;
                  else begin
                     y_in = '0;
                     if (CW'(x_ff + chunk_ff) < CW'(EDGE)) x_in = x_ff + chunk_ff;
                     else begin
                        st_in = S_DIA; x_in = '0; y_in = half;
                     end
                  end
               end else begin
                  if (CW'(y_ff + chunk_ff) < CW'(EDGE)) y_in = y_ff + chunk_ff;
                  else if (CW'(x_ff + half) < CW'(EDGE)) begin
                     x_in = x_ff + half;
                     // next column starts at (x+2*half) % chunk
                     y_in = (CW'(x_ff + chunk_ff) & (chunk_ff - CW'(1)));
                  end else if (chunk_ff > CW'(2)) begin
                     chunk_in = half; lv_in = lv_ff + 4'd1;
                     x_in = '0; y_in = '0; st_in = S_SQ;
                  end else st_in = S_WAIT;
               end
            end
         end
         S_WAIT: begin
            done = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; issued_ff <= 1'b0;
      end else begin
         st_ff <= st_in; issued_ff <= issued_in;
      end
      x_ff <= x_in; y_ff <= y_in; chunk_ff <= chunk_in; lv_ff <= lv_in; cn_ff <= cn_in;
   end
endmodule

/* design/diamond_square_terrain_generator.sv */
// ----------------------------------------------------------------------------
// diamond_square_terrain_generator: diamond-square heightmap engine
// Generates a (2^GRID_LOG2+1)-square Q8.8 height grid and reads points back.
// ----------------------------------------------------------------------------
// Usage: program min/max height, roughness and seed on the csr_ port while
// idle. A request with func 0 (tuser) rebuilds the grid; its response carries
// height 0 and is_read 0. A request with func 1 and col/row in tdata returns
// the stored height with is_read 1.
// A read request's height is read from the grid memory and registered, and
// the response is then registered in the output register. A generate walks
// every grid point through one shared point engine: 4 memory fetches (none
// for a corner), one LFSR multiply, a saturating add, a write (plus the
// edge-copy writes for a diamond point) and a handoff back to the controller.
// Fetches go one at a time through the single grid memory read port.
// One request is in flight at a time; a finished response sits in an
// output register while rsp_tvalid is high, and no new request is taken
// until it is consumed.
// Reset returns the LFSR to one and the CSR registers to their defaults; the
// grid holds no meaning until the first generate.
// ----------------------------------------------------------------------------
module diamond_square_terrain_generator #(
   parameter int GRID_LOG2 = dsq_pkg::GRID_LOG2_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // col[5:0], row[11:6], zero pad
   input  logic        req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // height[15:0]
   output logic        rsp_tuser,   // is_read
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import dsq_pkg::*;

   logic signed [15:0] min_ff, max_ff;
   logic [14:0]        rough_ff;
   logic [31:0]        seed_ff;
   dp_cmd_type         cmd;
   dp_status_type      status;
   logic signed [15:0] rd_height;
   logic               done, done_read;
   logic               v_ff;
   logic [15:0]        d_ff;
   logic               u_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0; max_ff <= 16'sd25600; rough_ff <= 15'd2560; seed_ff <= 32'd1;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_HEIGHT: min_ff <= csr_wdata[15:0];
            CSR_MAX_HEIGHT: max_ff <= csr_wdata[15:0];
            CSR_ROUGHNESS:  rough_ff <= csr_wdata[14:0];
            CSR_SEED:       seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   dsq_controller #(.GRID_LOG2(GRID_LOG2)) u_ctrl (
      .clock, .reset, .req_valid(req_tvalid), .req_func(req_tuser),
      .req_col(req_tdata[5:0]), .req_row(req_tdata[11:6]), .req_ready(req_tready),
      .status, .cmd, .done, .done_read, .out_free(!v_ff)
   );

   dsq_datapath #(.GRID_LOG2(GRID_LOG2)) u_dp (
      .clock, .reset, .cmd, .status, .min_height(min_ff), .max_height(max_ff),
      .roughness(rough_ff), .seed(seed_ff), .rd_height
   );

   always_ff @(posedge clock) begin
      if (reset) v_ff <= 1'b0;
      else if (done) v_ff <= 1'b1;
      else if (rsp_tready) v_ff <= 1'b0;
      if (done) begin
         d_ff <= done_read ? rd_height : 16'd0;
         u_ff <= done_read;
      end
   end

   assign rsp_tvalid = v_ff;
   assign rsp_tdata = d_ff;
   assign rsp_tuser = u_ff;

   logic unused_ok;
   assign unused_ok = ^req_tdata[15:12];

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while response pending");
   a_done_frees: assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_tvalid) else $error("done lost");
   a_read_tag: assert property (@(posedge clock) disable iff (reset)
      done_read |-> done) else $error("read done without done");
endmodule

/* bench/tb_diamond_square_terrain_generator.sv */
// ----------------------------------------------------------------------------
// tb_diamond_square_terrain_generator: self-checking bench
// Drives generate and read requests, predicts every response from its own
// diamond-square model and checks them in order; varies the height range,
// roughness and seed, and stalls both sides at random.
// ----------------------------------------------------------------------------
module tb_diamond_square_terrain_generator;
   import dsq_pkg::*;

   localparam int LOG2 = 5;
   localparam int EDGE = 1 << LOG2;
   localparam int SIDE = EDGE + 1;
   localparam int WATCHDOG = 200000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        req_tuser = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_wen = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   typedef struct {
      logic [15:0] height;
      logic        is_read;
   } terrain_rsp_type;

   terrain_rsp_type pending_q[$];
   logic signed [15:0] terrain_grid [SIDE*SIDE];
   logic signed [15:0] lo_height, hi_height;
   logic [14:0] rough_amp;
   logic [31:0] seed_val, noise;
   int   errors, n_gen, n_read, n_rsp, idle_cycles;
   bit   send_calm, recv_calm, recv_hold;

   diamond_square_terrain_generator #(.GRID_LOG2(LOG2)) i_dut (.*);

   initial forever #5 clock = ~clock;

   function automatic logic [31:0] lfsr_next(logic [31:0] s);
      logic [31:0] n;
      n = s >> 1;
      if (s[0]) n = n ^ 32'h8020_0003;
      return n;
   endfunction

   function automatic int draw_uniform(int lo, int hi);
      longint unsigned span, r;
      noise = lfsr_next(noise);
      span = longint'(hi - lo) + 1;
      r = noise;
      return lo + int'((r * span) >> 32);
   endfunction

   function automatic int cell_at(int x, int y);
      return terrain_grid[y*SIDE + x];
   endfunction

   function automatic int floor_mean(int a, int b, int c, int d);
      return (a + b + c + d) >>> 2;
   endfunction

   function automatic logic [15:0] clip16(int v);
      if (v > 32767) return 16'h7fff;
      if (v < -32768) return 16'h8000;
      return v[15:0];
   endfunction

   task automatic build_terrain();
      int lo, hi, t, chunk, half, lvl, amp, m, mask;
      logic [15:0] v;
      lo = lo_height; hi = hi_height;
      if (hi < lo) begin t = lo; lo = hi; hi = t; end
      noise = (seed_val == 0) ? 32'd1 : seed_val;
      terrain_grid[0] = 16'(draw_uniform(lo, hi));
      terrain_grid[EDGE] = 16'(draw_uniform(lo, hi));
      terrain_grid[EDGE*SIDE] = 16'(draw_uniform(lo, hi));
      terrain_grid[EDGE*SIDE + EDGE] = 16'(draw_uniform(lo, hi));
      mask = EDGE - 1;
      lvl = 0;
      for (chunk = EDGE; chunk > 1; chunk = chunk >> 1) begin
         amp = rough_amp >> lvl;
         half = chunk >> 1;
         for (int x = 0; x < EDGE; x += chunk)
            for (int y = 0; y < EDGE; y += chunk) begin
               m = floor_mean(cell_at(x, y), cell_at(x+chunk, y),
                              cell_at(x, y+chunk), cell_at(x+chunk, y+chunk));
               terrain_grid[(y+half)*SIDE + x+half] = clip16(m + draw_uniform(-amp, amp));
            end
         for (int x = 0; x < EDGE; x += half)
            for (int y = (x + half) % chunk; y < EDGE; y += chunk) begin
               m = floor_mean(cell_at((x - half + EDGE) & mask, y),
                              cell_at((x + half) & mask, y),
                              cell_at(x, (y + half) & mask),
                              cell_at(x, (y - half + EDGE) & mask));
               v = clip16(m + draw_uniform(-amp, amp));
               terrain_grid[y*SIDE + x] = v;
               if (x == 0) terrain_grid[y*SIDE + EDGE] = v;
               if (y == 0) terrain_grid[EDGE*SIDE + x] = v;
            end
         lvl++;
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] val);
      csr_wen <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_wen <= 0;
      @(posedge clock);
      case (idx)
         CSR_MIN_HEIGHT: lo_height = val[15:0];
         CSR_MAX_HEIGHT: hi_height = val[15:0];
         CSR_ROUGHNESS:  rough_amp = val[14:0];
         default:        seed_val = val;
      endcase
   endtask

   // one request; random gaps may be inserted before raising valid
   task automatic send_request(bit func, logic [5:0] col, logic [5:0] row);
      terrain_rsp_type e;
      int x, y;
      while (!send_calm && $urandom_range(99) < 9) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= func;
      req_tdata <= {4'b0, row, col};
      do @(posedge clock); while (!req_tready);
      if (!func) begin
         build_terrain(); n_gen++;
         e.height = '0; e.is_read = 0;
      end else begin
         x = (col > EDGE) ? EDGE : col;
         y = (row > EDGE) ? EDGE : row;
         e.height = terrain_grid[y*SIDE + x]; e.is_read = 1; n_read++;
      end
      pending_q.push_back(e);
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic read_random(int n);
      repeat (n) send_request(1, 6'($urandom_range(63)), 6'($urandom_range(63)));
   endtask

   // receiver and response check
   initial begin
      terrain_rsp_type e;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            n_rsp++;
            if (pending_q.size() == 0) begin
               $error("unexpected response height=%h is_read=%b", rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               e = pending_q.pop_front();
               if (rsp_tdata !== e.height) begin
                  $error("height expected %h actual %h", e.height, rsp_tdata); errors++;
               end
               if (rsp_tuser !== e.is_read) begin
                  $error("is_read expected %b actual %b", e.is_read, rsp_tuser); errors++;
               end
            end
         end
         if (recv_hold) rsp_tready <= 0;
         else rsp_tready <= recv_calm || ($urandom_range(99) >= 9);
      end
   end

   // watchdog on accepted handshakes
   initial begin
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
            idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   task automatic test_defaults_and_corners();
      send_request(0, 0, 0);
      send_request(1, 0, 0);  send_request(1, 32, 0);
      send_request(1, 0, 32); send_request(1, 32, 32);
      send_request(1, 63, 63); send_request(1, 33, 5);
      send_request(1, 16, 16); send_request(1, 5, 63);
      send_request(1, 6'h2a, 6'h15); send_request(1, 6'h15, 6'h2a);
      drain();
   endtask

   task automatic test_extremes();
      // saturation toward top, zero seed, full roughness
      write_csr(CSR_MIN_HEIGHT, 32'h7f00); write_csr(CSR_MAX_HEIGHT, 32'h7fff);
      write_csr(CSR_ROUGHNESS, 32'h7fff);  write_csr(CSR_SEED, 32'h0);
      send_request(0, 0, 0); read_random(4); drain();
      // reversed range at the negative end, no noise
      write_csr(CSR_MIN_HEIGHT, 32'hffff_8000 & 32'hffff ^ 32'h0 | 32'h7fff);
      write_csr(CSR_MAX_HEIGHT, 32'h8000);
      write_csr(CSR_ROUGHNESS, 32'h0); write_csr(CSR_SEED, 32'hffff_ffff);
      send_request(0, 0, 0); read_random(4); drain();
   endtask

   task automatic test_backpressure();
      recv_hold = 1;
      fork
         begin repeat (300) @(posedge clock); recv_hold = 0; end
         begin
            send_request(1, 3, 4); send_request(1, 7, 9); send_request(1, 32, 1);
            read_random(3);
         end
      join
      drain();
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < 5; p++) begin
         write_csr(CSR_MIN_HEIGHT, $urandom);
         write_csr(CSR_MAX_HEIGHT, $urandom);
         write_csr(CSR_ROUGHNESS, $urandom);
         write_csr(CSR_SEED, $urandom);
         send_calm = (p == 2); recv_calm = (p == 2);
         send_request(0, 6'($urandom), 6'($urandom));
         read_random(15);
         drain();   // sender pauses until all responses are in
      end
      send_calm = 0; recv_calm = 0;
   endtask

   initial begin
      lo_height = 0; hi_height = 16'd25600; rough_amp = 15'd2560; seed_val = 1;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_defaults_and_corners();
      test_extremes();
      test_backpressure();
      test_random_phases();
      drain();
      $display("covered %0d generates and %0d reads, %0d responses checked",
               n_gen, n_read, n_rsp);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
